@@ rtl/core/sjis_to_jis_stream_converter_unit_macros.svh @@
// Assertion macros shared by the converter RTL.
`ifndef SJIS_TO_JIS_STREAM_CONVERTER_UNIT_MACROS_SVH
`define SJIS_TO_JIS_STREAM_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, held off during reset
`define STJ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also holds through reset
`define STJ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define STJ_ASSERT_RST(lbl, prop, msg)
`define STJ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/stj_pkg.sv @@
// Types, constants and conversion functions for the SJIS to JIS converter.
`default_nettype none

package stj_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic REG_ASCII_MODE = 1'b0;
    localparam logic REG_CHAR_LIMIT = 1'b1;

    // Reset values
    localparam logic        ASCII_MODE_RST = 1'b0;
    localparam logic [15:0] CHAR_LIMIT_RST = 16'hFFFF;

    // Byte codes
    localparam logic [7:0] BYTE_TERM    = 8'h00;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] PRINT_LO     = 8'h21;
    localparam logic [7:0] PRINT_HI     = 8'h7E;
    localparam logic [7:0] LEAD1_LO     = 8'h81;
    localparam logic [7:0] LEAD1_HI     = 8'h9F;
    localparam logic [7:0] LEAD2_LO     = 8'hE0;
    localparam logic [7:0] LEAD2_HI     = 8'hEF;
    localparam logic [7:0] TRAIL_SPLIT  = 8'h9F;
    localparam logic [7:0] TRAIL_GAP    = 8'h7F;
    localparam logic [7:0] ROW1_EVEN    = 8'h21;
    localparam logic [7:0] ROW1_ODD     = 8'h22;
    localparam logic [7:0] ROW2_EVEN    = 8'h5F;
    localparam logic [7:0] ROW2_ODD     = 8'h60;
    localparam logic [7:0] CELL_OFS_LO  = 8'h1F;
    localparam logic [7:0] CELL_OFS_HI  = 8'h7E;

    // JIS codes
    localparam logic [15:0] JIS_SPACE   = 16'h2121;
    localparam logic [15:0] JIS_END     = 16'h0000;
    localparam logic [7:0]  JIS_ROW_ALNUM = 8'h23;

    typedef struct packed {
        logic        ascii_mode;
        logic [15:0] char_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  held_lead;
        logic        lead_pending;
        logic [15:0] emitted_count;
    } t_state;

    function automatic logic is_lead(input logic [7:0] b);
        return ((b >= LEAD1_LO) && (b <= LEAD1_HI)) || ((b >= LEAD2_LO) && (b <= LEAD2_HI));
    endfunction

    function automatic logic is_print(input logic [7:0] b);
        return (b >= PRINT_LO) && (b <= PRINT_HI);
    endfunction

    // Lead/trail pair to row/cell, 8-bit wrapping
    function automatic logic [15:0] pair_to_jis(input logic [7:0] hi, input logic [7:0] lo);
        logic       low_half;
        logic [7:0] base;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] lo_adj;
        low_half = (hi <= LEAD1_HI);
        base     = low_half ? ((hi - LEAD1_LO) << 1) : ((hi - LEAD2_LO) << 1);
        lo_adj   = (lo >= TRAIL_GAP) ? (lo - 8'd1) : lo;
        if (lo < TRAIL_SPLIT) begin
            row = base + (low_half ? ROW1_EVEN : ROW2_EVEN);
            col = lo_adj - CELL_OFS_LO;
        end else begin
            row = base + (low_half ? ROW1_ODD : ROW2_ODD);
            col = lo - CELL_OFS_HI;
        end
        return {row, col};
    endfunction

    // Full-width table for printable ASCII; digits and letters sit in row 0x23
    function automatic logic [15:0] fullwidth(input logic [7:0] b);
        logic [15:0] code;
        priority if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                     (b >= 8'h61 && b <= 8'h7A)) begin
            code = {JIS_ROW_ALNUM, b};
        end else begin
            unique case (b)
                8'h21:   code = 16'h212A;
                8'h22:   code = 16'h7C7E;
                8'h23:   code = 16'h2174;
                8'h24:   code = 16'h2170;
                8'h25:   code = 16'h2173;
                8'h26:   code = 16'h2175;
                8'h27:   code = 16'h7C7D;
                8'h28:   code = 16'h214A;
                8'h29:   code = 16'h214B;
                8'h2A:   code = 16'h2176;
                8'h2B:   code = 16'h215C;
                8'h2C:   code = 16'h2124;
                8'h2D:   code = 16'h215D;
                8'h2E:   code = 16'h2125;
                8'h2F:   code = 16'h213F;
                8'h3A:   code = 16'h2127;
                8'h3B:   code = 16'h2128;
                8'h3C:   code = 16'h2163;
                8'h3D:   code = 16'h2161;
                8'h3E:   code = 16'h2164;
                8'h3F:   code = 16'h2129;
                8'h40:   code = 16'h2177;
                8'h5B:   code = 16'h214E;
                8'h5C:   code = 16'h2140;
                8'h5D:   code = 16'h214F;
                8'h5E:   code = 16'h2130;
                8'h5F:   code = 16'h2132;
                8'h60:   code = 16'h212E;
                8'h7B:   code = 16'h2150;
                8'h7C:   code = 16'h2143;
                8'h7D:   code = 16'h2151;
                8'h7E:   code = 16'h2141;
                default: code = JIS_SPACE;
            endcase
        end
        return code;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/stj_cfg_regs.sv @@
// APB-style configuration registers of the converter.
`default_nettype none

module stj_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [stj_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [stj_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [stj_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output stj_pkg::t_cfg                       o_cfg
);
    import stj_pkg::*;

    t_cfg r_cfg;
    logic reg_idx;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ascii_mode <= ASCII_MODE_RST;
            r_cfg.char_limit <= CHAR_LIMIT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ASCII_MODE: r_cfg.ascii_mode <= pwdata[0];
                REG_CHAR_LIMIT: r_cfg.char_limit <= pwdata[15:0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_ASCII_MODE: prdata = {{(CFG_DATA_W-1){1'b0}}, r_cfg.ascii_mode};
            REG_CHAR_LIMIT: prdata = {{(CFG_DATA_W-16){1'b0}}, r_cfg.char_limit};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/stj_state_mem.sv @@
// One-entry state memory with registered read and write-first bypass.
`default_nettype none

module stj_state_mem (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic              i_wr_en,
    input  wire stj_pkg::t_state   i_wr_data,
    output stj_pkg::t_state        o_rd_data
);
    import stj_pkg::*;

    t_state r_mem [0:0];
    logic   r_valid;
    t_state r_rd_data;

    assign o_rd_data = r_rd_data;

    // Entry valid bit: an unwritten entry reads as the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid <= 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[0] <= i_wr_data;
        end
    end

    // Registered read, forwarding a write of the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en) begin
                r_rd_data <= i_wr_data;
            end else if (r_valid) begin
                r_rd_data <= r_mem[0];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sjis_to_jis_stream_converter_unit.sv @@
// Top level of the SJIS to JIS X 0208 stream converter.
//
//  channel  direction  handshake             payload
//  input    in         i_valid / o_ready     i_in_byte
//  result   out        o_valid / i_ready     o_jis_word, o_char_count, o_end_of_string
//  config   in         psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One item per cycle sustained while the output is not stalled. The state is read at
// the accepting edge, and the execute stage writes the result into the output register.
// State read-modify-write is one per cycle, with a bypass into the read register.
// Reset is synchronous and clears the pipeline, the state entry and the registers.
// A stalled output register holds the execute stage, which in turn holds input.
`default_nettype none

`include "sjis_to_jis_stream_converter_unit_macros.svh"

module sjis_to_jis_stream_converter_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [7:0]                     i_in_byte,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [15:0]                    o_jis_word,
    output logic      [15:0]                    o_char_count,
    output logic                                o_end_of_string,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [stj_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [stj_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [stj_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import stj_pkg::*;

    t_cfg        cfg;
    t_state      cur_state;
    t_state      n_state;
    logic        in_accept;
    logic        fire;
    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        res_valid;
    logic [15:0] res_code;
    logic [15:0] res_count;
    logic        res_end;
    logic        r_out_valid;
    logic [15:0] r_out_code;
    logic [15:0] r_out_count;
    logic        r_out_end;

    stj_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    stj_state_mem u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_wr_en   (fire),
        .i_wr_data (n_state),
        .o_rd_data (cur_state)
    );

    // Handshake
    assign fire      = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || fire;
    assign in_accept = i_valid && o_ready;

    // Execute stage holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte <= i_in_byte;
        end
    end

    // Byte decode and state update
    always_comb begin
        n_state   = cur_state;
        res_valid = 1'b0;
        res_code  = JIS_END;
        res_count = cur_state.emitted_count + 16'd1;
        res_end   = 1'b0;
        priority if (r_s1_byte == BYTE_TERM) begin
            res_valid = 1'b1;
            res_count = cur_state.emitted_count;
            res_end   = 1'b1;
            n_state   = '0;
        end else if (cur_state.emitted_count >= cfg.char_limit) begin
            // limit reached: byte ignored, state kept
            n_state = cur_state;
        end else if (cur_state.lead_pending) begin
            res_valid            = 1'b1;
            res_code             = pair_to_jis(cur_state.held_lead, r_s1_byte);
            n_state.lead_pending = 1'b0;
            n_state.held_lead    = '0;
        end else if (r_s1_byte == BYTE_SPACE) begin
            res_valid = 1'b1;
            res_code  = JIS_SPACE;
        end else if (cfg.ascii_mode && is_print(r_s1_byte)) begin
            res_valid = 1'b1;
            res_code  = fullwidth(r_s1_byte);
        end else if (is_lead(r_s1_byte)) begin
            n_state.held_lead    = r_s1_byte;
            n_state.lead_pending = 1'b1;
        end else begin
            // dropped single byte
            n_state = cur_state;
        end
        if (res_valid && !res_end) begin
            n_state.emitted_count = res_count;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out_code  <= res_code;
            r_out_count <= res_count;
            r_out_end   <= res_end;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_jis_word      = r_out_code;
    assign o_char_count    = r_out_count;
    assign o_end_of_string = r_out_end;

    // Checks
    `STJ_ASSERT_RST(a_char_count_nonzero, (o_valid && !o_end_of_string) |-> (o_char_count != 16'd0), "character result with zero count")
    `STJ_ASSERT_RST(a_term_clears_state, (fire && (r_s1_byte == BYTE_TERM)) |-> (n_state == '0), "terminator did not clear state")
    `STJ_ASSERT_RST(a_count_step, (fire && res_valid && !res_end) |-> (n_state.emitted_count == cur_state.emitted_count + 16'd1), "count did not step by one")
    `STJ_ASSERT_ALWAYS(a_no_fire_when_full, (r_out_valid && !i_ready) |-> !fire, "execute fired into a stalled output")

endmodule

`default_nettype wire

@@ tb/sv/tb_sjis_to_jis_stream_converter_unit.sv @@
// Self-checking testbench for the SJIS to JIS X 0208 stream converter.
module tb_sjis_to_jis_stream_converter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import stj_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RX_LONG_HOLD  = 60;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int N_DIRECTED    = 30;

    // Register byte addresses
    localparam logic [CFG_ADDR_W-1:0] ADDR_ASCII_MODE = {REG_ASCII_MODE, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_CHAR_LIMIT = {REG_CHAR_LIMIT, 2'b00};

    typedef struct packed {
        logic [15:0] jis;
        logic [15:0] cnt;
        logic        eos;
    } t_jis_result;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  byte_or_addr;
        logic [15:0] cfg_value;
        bit          typed;
        t_jis_result exp;
    } t_dir_row;

    // DUT signals
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [7:0]            i_in_byte;
    logic                  o_valid;
    logic                  i_ready;
    logic [15:0]           o_jis_word;
    logic [15:0]           o_char_count;
    logic                  o_end_of_string;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sjis_to_jis_stream_converter_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_jis_word      (o_jis_word),
        .o_char_count    (o_char_count),
        .o_end_of_string (o_end_of_string),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Full-width codes for 0x20..0x7E
    logic [15:0] fullwidth_codes [0:94] = '{
        16'h2121, 16'h212A, 16'h7C7E, 16'h2174, 16'h2170, 16'h2173, 16'h2175, 16'h7C7D,
        16'h214A, 16'h214B, 16'h2176, 16'h215C, 16'h2124, 16'h215D, 16'h2125, 16'h213F,
        16'h2330, 16'h2331, 16'h2332, 16'h2333, 16'h2334, 16'h2335, 16'h2336, 16'h2337,
        16'h2338, 16'h2339, 16'h2127, 16'h2128, 16'h2163, 16'h2161, 16'h2164, 16'h2129,
        16'h2177, 16'h2341, 16'h2342, 16'h2343, 16'h2344, 16'h2345, 16'h2346, 16'h2347,
        16'h2348, 16'h2349, 16'h234A, 16'h234B, 16'h234C, 16'h234D, 16'h234E, 16'h234F,
        16'h2350, 16'h2351, 16'h2352, 16'h2353, 16'h2354, 16'h2355, 16'h2356, 16'h2357,
        16'h2358, 16'h2359, 16'h235A, 16'h214E, 16'h2140, 16'h214F, 16'h2130, 16'h2132,
        16'h212E, 16'h2361, 16'h2362, 16'h2363, 16'h2364, 16'h2365, 16'h2366, 16'h2367,
        16'h2368, 16'h2369, 16'h236A, 16'h236B, 16'h236C, 16'h236D, 16'h236E, 16'h236F,
        16'h2370, 16'h2371, 16'h2372, 16'h2373, 16'h2374, 16'h2375, 16'h2376, 16'h2377,
        16'h2378, 16'h2379, 16'h237A, 16'h2150, 16'h2143, 16'h2151, 16'h2141
    };

    // Directed stimulus; typed expectations only where obvious
    t_dir_row directed_rows [N_DIRECTED] = '{
        // terminator right after reset
        '{ROW_BYTE, 8'h00, 16'h0, 1'b1, '{16'h0000, 16'd0, 1'b1}},
        '{ROW_BYTE, 8'h20, 16'h0, 1'b1, '{16'h2121, 16'd1, 1'b0}},
        // ascii byte outside ascii mode is dropped
        '{ROW_BYTE, 8'h41, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h81, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h40, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'hEF, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'hFC, 16'h0, 1'b0, '0},
        // space taken as a trail byte
        '{ROW_BYTE, 8'h9F, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h20, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'hE0, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h7F, 16'h0, 1'b0, '0},
        // single bytes that are dropped
        '{ROW_BYTE, 8'h01, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'hA0, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'hDF, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h80, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h7F, 16'h0, 1'b0, '0},
        // dangling lead dropped by the terminator
        '{ROW_BYTE, 8'h81, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 16'h0, 1'b1, '{16'h0000, 16'd5, 1'b1}},
        // ascii mode with a small limit
        '{ROW_CFG,  {5'd0, ADDR_ASCII_MODE}, 16'd1, 1'b0, '0},
        '{ROW_CFG,  {5'd0, ADDR_CHAR_LIMIT}, 16'd3, 1'b0, '0},
        '{ROW_BYTE, 8'h21, 16'h0, 1'b1, '{16'h212A, 16'd1, 1'b0}},
        '{ROW_BYTE, 8'h22, 16'h0, 1'b1, '{16'h7C7E, 16'd2, 1'b0}},
        '{ROW_BYTE, 8'h7E, 16'h0, 1'b1, '{16'h2141, 16'd3, 1'b0}},
        // limit reached: bytes ignored until the terminator
        '{ROW_BYTE, 8'h30, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h81, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 16'h0, 1'b1, '{16'h0000, 16'd3, 1'b1}},
        // zero limit
        '{ROW_CFG,  {5'd0, ADDR_CHAR_LIMIT}, 16'd0, 1'b0, '0},
        '{ROW_BYTE, 8'h20, 16'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 16'h0, 1'b1, '{16'h0000, 16'd0, 1'b1}}
    };

    // Predictor state and configuration
    logic        cfg_ascii;
    logic [15:0] cfg_limit;
    logic [7:0]  pred_lead;
    logic        pred_pending;
    logic [15:0] pred_count;

    t_jis_result pending_results [$];
    int          err_count;
    int          sent_items;
    int          cycle_count;
    int          hold_requests;
    bit          tx_no_idle;
    bit          rx_no_idle;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Lead/trail pair to row and cell, 8-bit wrapping
    function automatic logic [15:0] sjis_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic       first_half;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] lo_adj;
        first_half = (hi <= 8'h9F);
        lo_adj     = (lo >= 8'h7F) ? lo - 8'd1 : lo;
        if (lo < 8'h9F) begin
            row = first_half ? (hi - 8'h81) * 8'd2 + 8'h21 : (hi - 8'hE0) * 8'd2 + 8'h5F;
            col = lo_adj - 8'h1F;
        end else begin
            row = first_half ? (hi - 8'h81) * 8'd2 + 8'h22 : (hi - 8'hE0) * 8'd2 + 8'h60;
            col = lo - 8'h7E;
        end
        return {row, col};
    endfunction

    // Advance the predictor by one accepted byte, queue any result
    task automatic convert_byte(input logic [7:0] b, input bit typed, input t_jis_result typed_res);
        t_jis_result res;
        bit          emit;
        emit = 1'b0;
        res  = '0;
        if (b == 8'h00) begin
            res          = '{jis: 16'h0000, cnt: pred_count, eos: 1'b1};
            emit         = 1'b1;
            pred_lead    = 8'h00;
            pred_pending = 1'b0;
            pred_count   = 16'd0;
        end else if (pred_count < cfg_limit) begin
            if (pred_pending) begin
                res.jis      = sjis_pair(pred_lead, b);
                pred_pending = 1'b0;
                pred_lead    = 8'h00;
                emit         = 1'b1;
            end else if (b == 8'h20) begin
                res.jis = 16'h2121;
                emit    = 1'b1;
            end else if (cfg_ascii && b >= 8'h21 && b <= 8'h7E) begin
                res.jis = fullwidth_codes[b - 8'h20];
                emit    = 1'b1;
            end else if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF)) begin
                pred_lead    = b;
                pred_pending = 1'b1;
            end
            if (emit) begin
                pred_count = pred_count + 16'd1;
                res.cnt    = pred_count;
                res.eos    = 1'b0;
            end
        end
        if (emit) begin
            pending_results.push_back(typed ? typed_res : res);
        end
    endtask

    // Offer one item after a random gap; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_jis_result typed_res = '0);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_in_byte = b;
        do @(posedge i_clk); while (!o_ready);
        convert_byte(b, typed, typed_res);
        sent_items++;
        @(negedge i_clk);
    endtask

    // Stop offering until every result has come, then let the pipeline empty
    task automatic wait_drained(input int extra_cycles);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (extra_cycles) @(negedge i_clk);
    endtask

    // Register write: setup then access phase
    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_ASCII_MODE) cfg_ascii = data[0];
        else if (addr == ADDR_CHAR_LIMIT) cfg_limit = data[15:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [7:0] random_lead();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h9F))
                                    : 8'($urandom_range(8'hE0, 8'hEF));
    endfunction

    // One random string: mostly well-formed characters, some noise
    task automatic send_string();
        int         n_chars;
        int         pick;
        logic [7:0] trail;
        n_chars = $urandom_range(0, 12);
        repeat (n_chars) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                trail = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(8'h40, 8'hFC))
                                                     : 8'($urandom_range(1, 255));
                send_byte(random_lead());
                send_byte(trail);
            end else if (pick < 65) begin
                send_byte(8'($urandom_range(8'h21, 8'h7E)));
            end else if (pick < 75) begin
                send_byte(8'h20);
            end else if (pick < 80) begin
                // lead cut short by the terminator
                send_byte(random_lead());
                send_byte(8'h00);
            end else begin
                send_byte(8'($urandom_range(1, 255)));
            end
        end
        // some strings run on without a terminator
        if ($urandom_range(0, 9) != 0) send_byte(8'h00);
    endtask

    function automatic logic [15:0] phase_limit(input int ph);
        case (ph)
            1:       return 16'd0;
            3:       return 16'd1;
            4:       return 16'($urandom_range(2, 30));
            6:       return 16'($urandom_range(0, 65535));
            7:       return 16'd8;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Result checker
    always @(posedge i_clk) begin : check_result
        t_jis_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result code=%h cnt=%0d eos=%b",
                         $realtime, o_jis_word, o_char_count, o_end_of_string);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_jis_word !== want.jis) begin
                    $display("%0t: code expected %h actual %h", $realtime, want.jis, o_jis_word);
                    err_count++;
                end
                if (o_char_count !== want.cnt) begin
                    $display("%0t: char_count expected %0d actual %0d",
                             $realtime, want.cnt, o_char_count);
                    err_count++;
                end
                if (o_end_of_string !== want.eos) begin
                    $display("%0t: end_of_string expected %b actual %b",
                             $realtime, want.eos, o_end_of_string);
                    err_count++;
                end
            end
        end
    end

    // Result side ready: random stall per item, plus long holds on request
    initial begin : result_ready_driver
        int wait_left;
        int holds_served;
        bit took;
        i_ready      = 1'b0;
        wait_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            took = o_valid && i_ready;
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                wait_left    = RX_LONG_HOLD;
            end else if (took) begin
                wait_left = rx_no_idle ? 0 : $urandom_range(0, 3);
            end
            if (wait_left > 0) begin
                i_ready = 1'b0;
                wait_left--;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        int ph;
        int target;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in_byte     = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        err_count     = 0;
        sent_items    = 0;
        cycle_count   = 0;
        hold_requests = 0;
        tx_no_idle    = 1'b0;
        rx_no_idle    = 1'b0;
        cfg_ascii     = ASCII_MODE_RST;
        cfg_limit     = CHAR_LIMIT_RST;
        pred_lead     = 8'h00;
        pred_pending  = 1'b0;
        pred_count    = 16'd0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                wait_drained(DRAIN_CYCLES);
                apb_write(directed_rows[r].byte_or_addr[CFG_ADDR_W-1:0],
                          CFG_DATA_W'(directed_rows[r].cfg_value));
            end else begin
                send_byte(directed_rows[r].byte_or_addr, directed_rows[r].typed,
                          directed_rows[r].exp);
            end
        end

        // random phases, each under its own settings
        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_drained(DRAIN_CYCLES);
            apb_write(ADDR_ASCII_MODE, CFG_DATA_W'(ph % 2));
            apb_write(ADDR_CHAR_LIMIT, CFG_DATA_W'(phase_limit(ph)));
            tx_no_idle = (ph == 3);
            rx_no_idle = (ph == 5);
            target     = sent_items + PHASE_ITEMS;
            if (ph == 2) begin
                // receiver holds off while items keep coming back to back
                hold_requests++;
                tx_no_idle = 1'b1;
                repeat (6) send_string();
                tx_no_idle = 1'b0;
            end
            while (sent_items < target) begin
                send_string();
                if ($urandom_range(0, 39) == 0) wait_drained(0);
            end
        end

        wait_drained(DRAIN_CYCLES);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/stj_pkg.sv
rtl/core/stj_cfg_regs.sv
rtl/core/stj_state_mem.sv
rtl/core/sjis_to_jis_stream_converter_unit.sv
tb/sv/tb_sjis_to_jis_stream_converter_unit.sv
